// ===== hw/rtl/chained_hash_map_long_key_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash map
// Shared property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_LONG_KEY_MACROS_SVH
`define CHAINED_HASH_MAP_LONG_KEY_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hw/rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash map package
// Sizes, operation codes and the bucket hash shared by the map modules.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int Buckets    = 16;
   localparam int Entries    = 256;
   localparam int BktW       = $clog2(Buckets);
   localparam int IdxW       = $clog2(Entries);
   localparam int LinkW      = IdxW + 1;
   localparam int CntW       = 9;
   localparam logic [31:0] HashPrime = 32'd1610612741;
   localparam logic [LinkW-1:0] Nil = LinkW'(Entries);

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_PUT    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      func_type          func;
      logic [63:0]       key;
      logic [63:0]       value;
      logic [BktW-1:0]   bucket;
   } cmd_type;

   function automatic logic [BktW-1:0] bucket_of(input logic [63:0] k);
      logic [31:0] prod;
      logic [31:0] h;
      prod = k[63:32] * HashPrime;
      h    = k[31:0] ^ prod;
      return h[BktW-1:0];
   endfunction

endpackage

// ===== hw/rtl/chm_front.sv =====
// ----------------------------------------------------------------------------
// Chained hash map front end
// Accepts requests, hashes the key into a bucket and queues the command.
// ----------------------------------------------------------------------------
module chm_front
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value_in,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   // Stage one registers the request, stage two holds the hashed command
   // in a two-entry queue.
   logic        s1_valid_ff, s1_valid_in;
   cmd_type     s1_ff;
   cmd_type     q_ff [2];
   logic [1:0]  q_cnt_ff, q_cnt_in;
   logic        q_rd_ff, q_rd_in;
   logic        q_wr_ff, q_wr_in;
   logic        push, pop;

   assign push      = s1_valid_ff && (q_cnt_ff != 2'd2);
   assign pop       = cmd_valid && cmd_ready;
   assign req_ready = !s1_valid_ff || push;
   assign cmd_valid = (q_cnt_ff != 2'd0);
   assign cmd       = q_ff[q_rd_ff];

   always_comb begin
      s1_valid_in = (req_valid && req_ready) ? 1'b1 : (push ? 1'b0 : s1_valid_ff);
      q_cnt_in    = q_cnt_ff + {1'b0, push} - {1'b0, pop};
      q_rd_in     = q_rd_ff ^ pop;
      q_wr_in     = q_wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         q_cnt_ff    <= 2'd0;
         q_rd_ff     <= 1'b0;
         q_wr_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         q_cnt_ff    <= q_cnt_in;
         q_rd_ff     <= q_rd_in;
         q_wr_ff     <= q_wr_in;
      end
      if (req_valid && req_ready) begin
         s1_ff.func   <= func_type'(req_func);
         s1_ff.key    <= req_key;
         s1_ff.value  <= req_value_in;
         s1_ff.bucket <= bucket_of(req_key);
      end
      if (push) q_ff[q_wr_ff] <= s1_ff;
   end

endmodule

// ===== hw/rtl/chm_back.sv =====
// ----------------------------------------------------------------------------
// Chained hash map back end
// Walks bucket chains in the entry memories and carries out each command.
// ----------------------------------------------------------------------------
module chm_back
   import chm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   output logic          cmd_ready,
   input  cmd_type       cmd,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_found,
   output logic [63:0]   rsp_value_out,
   output logic          rsp_status,
   output logic [8:0]    rsp_entry_count
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_HEAD, ST_RD, ST_CMP, ST_WR, ST_UNLINK, ST_FREE, ST_ALLOC,
      ST_RESP
   } state_type;

   // Entry memories; keys and values hold garbage until written.
   logic [63:0]       key_mem [Entries];
   logic [63:0]       val_mem [Entries];
   logic [LinkW-1:0]  link_mem [Entries];
   logic [LinkW-1:0]  head_ff [Buckets];

   state_type         state_ff;
   cmd_type           cur_ff;
   logic [LinkW-1:0]  ptr_ff, prev_ff, free_ff;
   logic [CntW-1:0]   cnt_ff;
   logic [IdxW:0]     init_ff;
   logic [63:0]       rd_key_ff, rd_val_ff;
   logic [LinkW-1:0]  rd_link_ff;
   logic [IdxW:0]     steps_ff;

   // Single read port feeding all three memories.
   logic [IdxW-1:0]   rd_addr;
   assign rd_addr = ptr_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[rd_addr];
      rd_val_ff  <= val_mem[rd_addr];
      rd_link_ff <= link_mem[rd_addr];
   end

   assign cmd_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         init_ff     <= '0;
         free_ff     <= '0;
         cnt_ff      <= '0;
         rsp_valid   <= 1'b0;
         cur_ff.func <= FUNC_LOOKUP;
         for (int b = 0; b < Buckets; b++) head_ff[b] <= Nil;
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               // Rebuild the free list one entry per cycle.
               link_mem[init_ff[IdxW-1:0]] <= LinkW'(init_ff) + LinkW'(1);
               if (init_ff == (IdxW+1)'(Entries - 1)) begin
                  // A clear answers only once the free list is whole again.
                  if (cur_ff.func == FUNC_CLEAR) begin
                     rsp_valid <= 1'b1;
                     state_ff  <= ST_RESP;
                  end else begin
                     state_ff  <= ST_IDLE;
                  end
               end
               init_ff <= init_ff + 1'b1;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff          <= cmd;
                  rsp_found       <= 1'b0;
                  rsp_value_out   <= '0;
                  rsp_status      <= 1'b0;
                  if (cmd.func == FUNC_CLEAR) begin
                     for (int b = 0; b < Buckets; b++) head_ff[b] <= Nil;
                     free_ff         <= '0;
                     cnt_ff          <= '0;
                     init_ff         <= '0;
                     rsp_entry_count <= '0;
                     state_ff        <= ST_INIT;
                  end else begin
                     state_ff <= ST_HEAD;
                  end
               end
            end
            ST_HEAD: begin
               ptr_ff   <= head_ff[cur_ff.bucket];
               prev_ff  <= Nil;
               steps_ff <= '0;
               state_ff <= ST_RD;
            end
            ST_RD: begin
               // Address is presented; memory data is valid next cycle.
               if (ptr_ff[IdxW] || steps_ff[IdxW]) begin
                  state_ff <= (cur_ff.func == FUNC_PUT) ? ST_FREE : ST_RESP;
                  if (cur_ff.func != FUNC_PUT) rsp_entry_count <= cnt_ff;
                  if (cur_ff.func != FUNC_PUT) rsp_valid <= 1'b1;
                  if (cur_ff.func == FUNC_PUT) ptr_ff <= free_ff;
               end else begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               if (rd_key_ff == cur_ff.key) begin
                  rsp_found <= 1'b1;
                  state_ff  <= ST_WR;
               end else begin
                  prev_ff  <= ptr_ff;
                  ptr_ff   <= rd_link_ff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_WR: begin
               unique case (cur_ff.func)
                  FUNC_LOOKUP: rsp_value_out <= rd_val_ff;
                  FUNC_PUT:    val_mem[rd_addr] <= cur_ff.value;
                  default: begin
                     if (prev_ff[IdxW]) head_ff[cur_ff.bucket] <= rd_link_ff;
                     else link_mem[prev_ff[IdxW-1:0]] <= rd_link_ff;
                  end
               endcase
               if (cur_ff.func == FUNC_REMOVE) begin
                  state_ff <= ST_UNLINK;
               end else begin
                  rsp_entry_count <= cnt_ff;
                  rsp_valid       <= 1'b1;
                  state_ff        <= ST_RESP;
               end
            end
            ST_UNLINK: begin
               link_mem[rd_addr] <= free_ff;
               free_ff           <= ptr_ff;
               cnt_ff            <= cnt_ff - 1'b1;
               rsp_entry_count   <= cnt_ff - 1'b1;
               rsp_valid         <= 1'b1;
               state_ff          <= ST_RESP;
            end
            ST_FREE: begin
               // The free head's link is read at the end of this cycle.
               state_ff <= ST_ALLOC;
            end
            ST_ALLOC: begin
               // rd_link_ff now holds the free head's successor.
               if (free_ff[IdxW]) begin
                  rsp_status <= 1'b1;
                  rsp_entry_count <= cnt_ff;
               end else begin
                  key_mem[rd_addr]  <= cur_ff.key;
                  val_mem[rd_addr]  <= cur_ff.value;
                  link_mem[rd_addr] <= head_ff[cur_ff.bucket];
                  head_ff[cur_ff.bucket] <= free_ff;
                  free_ff           <= rd_link_ff;
                  cnt_ff            <= cnt_ff + 1'b1;
                  rsp_entry_count   <= cnt_ff + 1'b1;
               end
               rsp_valid <= 1'b1;
               state_ff  <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/chained_hash_map_long_key.sv =====
// ----------------------------------------------------------------------------
// Chained hash map with 64-bit keys
// Top level joining the request front end to the chain-walking back end.
// ----------------------------------------------------------------------------
// Each lookup, put and remove walks its bucket chain through the single read
// port of the entry memories; a clear and the reset each rebuild the free list,
// during which the back end takes no command. The front end queues up to three
// requests while the back end is busy.
`include "chained_hash_map_long_key_macros.svh"

module chained_hash_map_long_key
   import chm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic signed [63:0] req_key,
   input  logic [63:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [63:0] rsp_value_out,
   output logic        rsp_status,
   output logic [8:0]  rsp_entry_count
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   chm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func,
      .req_key(req_key), .req_value_in,
      .cmd_valid, .cmd_ready, .cmd
   );

   chm_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp_found, .rsp_value_out, .rsp_status,
      .rsp_entry_count
   );

   `CHM_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_entry_count <= 9'(Entries))
   `CHM_ASSERT_IMPL(a_full_not_found, clock, reset, rsp_valid && rsp_status, !rsp_found)
   `CHM_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_valid && rsp_ready, !rsp_valid)

endmodule
